FILE: sv/pair_distance_histogram_unit_assert.svh
// assertion macros for the pair distance histogram unit
`ifndef PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PDH_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define PDH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PDH_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define PDH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/pdh_pkg.sv
// shared types and constants of the pair distance histogram unit
`default_nettype none
package pdh_pkg;
  localparam int BINS       = 256;
  localparam int BIN_W      = $clog2(BINS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int SQRT_STEPS = 33;
  localparam logic [31:0] HIST_INC = 32'd2;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [30:0] BOX_RESET = 31'd655360;
  localparam logic [31:0] INV_RESET = 32'd655360;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_PASS  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2,
    REG_INV   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic [65:0] sq;
    logic [7:0]  rbin;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;
endpackage
`default_nettype wire

FILE: sv/pdh_front.sv
// front end: takes transactions, wraps, squares and sums the pair distance
`default_nettype none
module pdh_front import pdh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] pos_a_x,
  input  wire logic [31:0] pos_a_y,
  input  wire logic [31:0] pos_a_z,
  input  wire logic [31:0] pos_b_x,
  input  wire logic [31:0] pos_b_y,
  input  wire logic [31:0] pos_b_z,
  input  wire logic [7:0]  read_bin,
  input  wire logic [30:0] box_x,
  input  wire logic [30:0] box_y,
  input  wire logic [30:0] box_z,
  input  wire fifo_stat_t  fstat,
  output logic             push,
  output item_t            push_item
);
  typedef enum logic [1:0] {F_IDLE, F_WRAP, F_SQ, F_PUSH} fstate_t;

  fstate_t     state;
  op_t         op;
  logic [7:0]  rbin;
  logic [31:0] ax, ay, az, bx, by, bz;
  logic [31:0] dx, dy, dz;
  logic [63:0] sx, sy, sz;
  logic [65:0] sum_next;

  function automatic logic [31:0] wrap_abs(logic [31:0] a, logic [31:0] b, logic [30:0] len);
    logic signed [34:0] d;
    logic signed [34:0] l;
    logic signed [34:0] h;
    logic signed [34:0] n;
    d = $signed({{3{a[31]}}, a}) - $signed({{3{b[31]}}, b});
    l = $signed({4'b0, len});
    h = $signed({5'b0, len[30:1]});
    if (d > h) begin
      d = d - l;
    end else if (d < -h) begin
      d = d + l;
    end
    n = -d;
    return d[34] ? n[31:0] : d[31:0];
  endfunction

  assign sum_next  = {2'b0, sx} + {2'b0, sy} + {2'b0, sz};
  assign in_ready  = (state == F_IDLE);
  assign push      = (state == F_PUSH) && !fstat.full;
  assign push_item = '{op: op, sq: (op == OP_ACC) ? sum_next : 66'd0, rbin: rbin};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= (op_t'(operation) == OP_ACC) ? F_WRAP : F_PUSH;
          end
        end
        F_WRAP: state <= F_SQ;
        F_SQ:   state <= F_PUSH;
        F_PUSH: begin
          if (!fstat.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op   <= op_t'(operation);
      rbin <= read_bin;
      ax   <= pos_a_x;
      ay   <= pos_a_y;
      az   <= pos_a_z;
      bx   <= pos_b_x;
      by   <= pos_b_y;
      bz   <= pos_b_z;
    end
    if (state == F_WRAP) begin
      dx <= wrap_abs(ax, bx, box_x);
      dy <= wrap_abs(ay, by, box_y);
      dz <= wrap_abs(az, bz, box_z);
    end
    if (state == F_SQ) begin
      sx <= dx * dx;
      sy <= dy * dy;
      sz <= dz * dz;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pdh_fifo.sv
// short queue between front and back end
`default_nettype none
module pdh_fifo import pdh_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output fifo_stat_t fstat
);
  item_t              slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count;

  assign pop_item    = slots[rptr];
  assign fstat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign fstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pdh_back.sv
// back end: root, bin scaling, histogram store and result register
`default_nettype none
module pdh_back import pdh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fifo_stat_t  fstat,
  input  wire item_t       pop_item,
  output logic             pop,
  input  wire logic [31:0] inv_bin_width,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      bin_value,
  output logic [31:0]      bin_index,
  output logic             in_range,
  output logic [31:0]      pass_count
);
  typedef enum logic [2:0] {B_IDLE, B_SQRT, B_MUL, B_BIN, B_RD, B_DATA, B_OUT} bstate_t;

  bstate_t     state;
  op_t         op;
  logic [65:0] rad;
  logic [35:0] rem;
  logic [32:0] root;
  logic [5:0]  cnt;
  logic        rh;
  logic [63:0] prod;
  logic [31:0] passes;
  logic [31:0] res_value, res_index;
  logic        res_hit;
  logic [BIN_W-1:0] addr;
  logic [31:0] mem [BINS];
  logic [BINS-1:0] vld;
  logic [31:0] rd_data;
  logic        rd_vld;
  logic [35:0] rem_sh, trial;
  logic [32:0] bin_sum;
  logic [31:0] bin_sat;
  logic [31:0] rbin_ext;
  logic [31:0] cur, incr;

  assign pop      = (state == B_IDLE) && !fstat.empty;
  assign rem_sh   = {rem[33:0], rad[65:64]};
  assign trial    = {1'b0, root, 2'b01};
  assign bin_sum  = (rh ? {1'b0, inv_bin_width} : 33'd0) + {1'b0, prod[63:32]};
  assign bin_sat  = bin_sum[32] ? CNT_MAX : bin_sum[31:0];
  assign rbin_ext = {24'd0, pop_item.rbin};
  assign cur      = rd_vld ? rd_data : 32'd0;
  assign incr     = (cur > CNT_MAX - HIST_INC) ? CNT_MAX : cur + HIST_INC;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      passes    <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!fstat.empty) begin
            op <= pop_item.op;
            unique case (pop_item.op)
              OP_ACC: begin
                rad   <= pop_item.sq;
                rem   <= '0;
                root  <= '0;
                cnt   <= 6'(SQRT_STEPS - 1);
                state <= B_SQRT;
              end
              OP_PASS: begin
                if (passes != CNT_MAX) begin
                  passes <= passes + 1'b1;
                end
                res_value <= '0;
                res_index <= '0;
                res_hit   <= 1'b0;
                state     <= B_OUT;
              end
              OP_READ: begin
                res_index <= rbin_ext;
                res_hit   <= 1'b0;
                addr      <= rbin_ext[BIN_W-1:0];
                if (rbin_ext < 32'(BINS)) begin
                  state <= B_RD;
                end else begin
                  res_value <= '0;
                  state     <= B_OUT;
                end
              end
              OP_CLEAR: begin
                passes    <= '0;
                vld       <= '0;
                res_value <= '0;
                res_index <= '0;
                res_hit   <= 1'b0;
                state     <= B_OUT;
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_SQRT: begin
          // one radicand digit pair per cycle
          rad <= {rad[63:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= root[31:0] * inv_bin_width;
          rh    <= root[32];
          state <= B_BIN;
        end
        B_BIN: begin
          res_index <= bin_sat;
          addr      <= bin_sat[BIN_W-1:0];
          if (bin_sat < 32'(BINS)) begin
            state <= B_RD;
          end else begin
            res_value <= '0;
            res_hit   <= 1'b0;
            state     <= B_OUT;
          end
        end
        B_RD: state <= B_DATA;
        B_DATA: begin
          if (op == OP_ACC) begin
            res_value <= incr;
            res_hit   <= 1'b1;
            vld[addr] <= 1'b1;
          end else begin
            res_value <= cur;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            bin_value  <= res_value;
            bin_index  <= res_index;
            in_range   <= res_hit;
            pass_count <= passes;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_RD) begin
      rd_data <= mem[addr];
      rd_vld  <= vld[addr];
    end
    if (state == B_DATA && op == OP_ACC) begin
      mem[addr] <= incr;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pair_distance_histogram_unit.sv
// top level of the pair distance histogram unit
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    operation, pos_a_*, pos_b_*, read_bin
// output    out        out_valid / out_ready  bin_value, bin_index, in_range, pass_count
// config    in         apb psel/penable       paddr, pwdata, prdata
//
// an accumulate transaction is wrapped, squared and summed in the front end, then passes
// through the 33-step bit-serial root in the back end
// read, pass and clear transactions skip the wrap and square states and the root
// the front end takes a new transaction only after it has pushed the last one,
// and runs ahead through a 4-deep queue
// reset clears the bin valid bits at once, so every bin reads as zero right after reset
// a stalled output holds the back end, a full queue holds the front end
`default_nettype none
`include "pair_distance_histogram_unit_assert.svh"
module pair_distance_histogram_unit import pdh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] pos_a_x,
  input  wire logic [31:0] pos_a_y,
  input  wire logic [31:0] pos_a_z,
  input  wire logic [31:0] pos_b_x,
  input  wire logic [31:0] pos_b_y,
  input  wire logic [31:0] pos_b_z,
  input  wire logic [7:0]  read_bin,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      bin_value,
  output logic [31:0]      bin_index,
  output logic             in_range,
  output logic [31:0]      pass_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // configuration registers
  logic [30:0] box_x, box_y, box_z;
  logic [31:0] inv_bin_width;
  cfg_reg_t    reg_sel;

  // queue between front and back end
  logic       push, pop;
  item_t      push_item, pop_item;
  fifo_stat_t fstat;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_BOX_X: prdata = {1'b0, box_x};
      REG_BOX_Y: prdata = {1'b0, box_y};
      REG_BOX_Z: prdata = {1'b0, box_z};
      REG_INV:   prdata = inv_bin_width;
      default:   prdata = '0;
    endcase
  end

  // register write on the apb access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x         <= BOX_RESET;
      box_y         <= BOX_RESET;
      box_z         <= BOX_RESET;
      inv_bin_width <= INV_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_BOX_X: box_x <= pwdata[30:0];
        REG_BOX_Y: box_y <= pwdata[30:0];
        REG_BOX_Z: box_z <= pwdata[30:0];
        REG_INV:   inv_bin_width <= pwdata;
        default:   box_x <= box_x;
      endcase
    end
  end

  // front end: wrap, square and sum
  pdh_front u_front (
    .clk, .rst, .in_valid, .in_ready, .operation,
    .pos_a_x, .pos_a_y, .pos_a_z, .pos_b_x, .pos_b_y, .pos_b_z, .read_bin,
    .box_x, .box_y, .box_z, .fstat, .push, .push_item
  );

  pdh_fifo u_fifo (
    .clk, .rst, .push, .push_item, .pop, .pop_item, .fstat
  );

  // back end: root, bin, histogram and result
  pdh_back u_back (
    .clk, .rst, .fstat, .pop_item, .pop, .inv_bin_width,
    .out_valid, .out_ready, .bin_value, .bin_index, .in_range, .pass_count
  );

  `PDH_ASSERT_NEVER(a_no_push_full, clk, rst, push && fstat.full, "push into full queue")
  `PDH_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && fstat.empty, "pop from empty queue")
  `PDH_ASSERT_IMP(a_hit_in_bins, clk, rst, out_valid && in_range, bin_index < 32'(BINS), "hit outside bins")
endmodule
`default_nettype wire
